// File: sv/bvwm_pkg.sv
// Package for the battery voltage window monitor: types, codes and constants.
`timescale 1ns / 1ps
`default_nettype none
package bvwm_pkg;

  // Counter limits and recovery confirm load
  localparam logic [15:0] AGE_MAX       = 16'd60000;
  localparam logic [7:0]  LOW_MAX       = 8'd250;
  localparam logic [4:0]  CONFIRM_TICKS = 5'd30;

  // Widths of the stream payloads
  localparam int unsigned IN_TDATA_W  = 16;
  localparam int unsigned OUT_TDATA_W = 8;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 16;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CUTOFF_LOW     = 3'd0,
    REG_AMP_CUT_LOW    = 3'd1,
    REG_FAULT_LOW      = 3'd2,
    REG_RECOVER_LOW    = 3'd3,
    REG_RECOVER_HIGH   = 3'd4,
    REG_FAULT_HIGH     = 3'd5,
    REG_MUTE_DELAY     = 3'd6,
    REG_SHUTDOWN_DELAY = 3'd7
  } reg_idx_e;

  // Voltage bands, in the order they are tested
  typedef enum logic [2:0] {
    BAND_TOO_LOW   = 3'd0,
    BAND_LOW_HYST  = 3'd1,
    BAND_GOOD      = 3'd2,
    BAND_HIGH_HYST = 3'd3,
    BAND_TOO_HIGH  = 3'd4
  } band_e;

  // Mute request codes
  typedef enum logic [1:0] {
    MUTE_NONE    = 2'd0,
    MUTE_REQUEST = 2'd1,
    MUTE_RELEASE = 2'd2
  } mute_e;

  typedef struct packed {
    logic [7:0]  cutoff_low;
    logic [7:0]  amp_cut_low;
    logic [7:0]  fault_low;
    logic [7:0]  recover_low;
    logic [7:0]  recover_high;
    logic [7:0]  fault_high;
    logic [7:0]  mute_delay;
    logic [15:0] shutdown_delay;
  } cfg_t;

  // Input item, first field in the highest bits
  typedef struct packed {
    logic       clear_need_reset;
    logic       normal_run;
    logic [7:0] sample;
  } item_t;

  // Classifier result for one sample
  typedef struct packed {
    band_e band;
    logic  below_amp_cut;
    logic  below_cutoff;
  } band_info_t;

  // Result item, first field in the highest bits
  typedef struct packed {
    logic  power_off_request;
    logic  emergency_off;
    logic  backlight_off;
    logic  amp_power_cut;
    mute_e mute_action;
    logic  need_reset;
    logic  power_error;
  } result_t;

endpackage
`default_nettype wire

// File: sv/bvwm_band.sv
// Sample classifier: sorts one sample into its voltage band.
`timescale 1ns / 1ps
`default_nettype none
module bvwm_band (
  input  wire logic [7:0]          sample_i,
  input  wire bvwm_pkg::cfg_t      cfg_i,
  output bvwm_pkg::band_info_t     info_o
);

  // Thresholds are tested strictly in order; no ordering is assumed
  always_comb begin
    if (sample_i < cfg_i.fault_low) begin
      info_o.band = bvwm_pkg::BAND_TOO_LOW;
    end else if (sample_i < cfg_i.recover_low) begin
      info_o.band = bvwm_pkg::BAND_LOW_HYST;
    end else if (sample_i < cfg_i.recover_high) begin
      info_o.band = bvwm_pkg::BAND_GOOD;
    end else if (sample_i < cfg_i.fault_high) begin
      info_o.band = bvwm_pkg::BAND_HIGH_HYST;
    end else begin
      info_o.band = bvwm_pkg::BAND_TOO_HIGH;
    end
    info_o.below_amp_cut = (sample_i < cfg_i.amp_cut_low);
    info_o.below_cutoff  = (sample_i < cfg_i.cutoff_low);
  end

endmodule
`default_nettype wire

// File: sv/bvwm_core.sv
// Monitor state (timers, flags) and the per-sample update and request logic.
`timescale 1ns / 1ps
`default_nettype none
module bvwm_core (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 step_i,
  input  wire bvwm_pkg::item_t      item_i,
  input  wire bvwm_pkg::cfg_t       cfg_i,
  input  wire bvwm_pkg::band_info_t info_i,
  output bvwm_pkg::result_t         result_o
);

  logic [15:0] fault_age_q, fault_age_d;
  logic [7:0]  low_count_q, low_count_d;
  logic [4:0]  confirm_count_q, confirm_count_d;
  logic        error_flag_q, error_flag_d;
  logic        reset_flag_q, reset_flag_d;

  logic [15:0] age_inc;
  logic [7:0]  low_inc;
  logic [4:0]  conf_dec;
  logic        rflag_pre;
  logic        emerg;

  // Counters step before the band decision
  assign age_inc   = (fault_age_q < bvwm_pkg::AGE_MAX) ? fault_age_q + 16'd1 : fault_age_q;
  assign low_inc   = (low_count_q < bvwm_pkg::LOW_MAX) ? low_count_q + 8'd1 : low_count_q;
  assign conf_dec  = (confirm_count_q != 5'd0) ? confirm_count_q - 5'd1 : 5'd0;
  assign rflag_pre = reset_flag_q & ~item_i.clear_need_reset;

  // Band actions
  always_comb begin
    fault_age_d     = 16'd0;
    low_count_d     = 8'd0;
    confirm_count_d = bvwm_pkg::CONFIRM_TICKS;
    error_flag_d    = error_flag_q;
    reset_flag_d    = rflag_pre;
    emerg           = 1'b0;
    result_o        = '0;
    result_o.mute_action = bvwm_pkg::MUTE_NONE;

    case (info_i.band)
      bvwm_pkg::BAND_TOO_LOW: begin
        error_flag_d = 1'b1;
        fault_age_d  = age_inc;
        low_count_d  = low_inc;
        if (low_inc > cfg_i.mute_delay) begin
          result_o.mute_action = bvwm_pkg::MUTE_REQUEST;
        end
        // Amp cut and the cutoff emergency held off while a reset is pending
        if (info_i.below_amp_cut && !rflag_pre) begin
          result_o.amp_power_cut = 1'b1;
          emerg = info_i.below_cutoff;
        end
        result_o.power_off_request = item_i.normal_run && (age_inc >= cfg_i.shutdown_delay);
      end
      bvwm_pkg::BAND_GOOD: begin
        confirm_count_d = conf_dec;
        if (conf_dec == 5'd0) begin
          error_flag_d         = 1'b0;
          result_o.mute_action = bvwm_pkg::MUTE_RELEASE;
        end
      end
      bvwm_pkg::BAND_TOO_HIGH: begin
        fault_age_d            = age_inc;
        result_o.mute_action   = bvwm_pkg::MUTE_REQUEST;
        result_o.backlight_off = 1'b1;
        emerg                  = 1'b1;
      end
      default: begin
        // both hysteresis bands: reload confirm, clear timers
      end
    endcase

    // Emergency power down always posts a power-off and latches the flags
    if (emerg) begin
      error_flag_d               = 1'b1;
      reset_flag_d               = 1'b1;
      result_o.power_off_request = 1'b1;
    end
    result_o.emergency_off = emerg;
    result_o.power_error   = error_flag_d;
    result_o.need_reset    = reset_flag_d;
  end

  // State registers, updated once per processed transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fault_age_q     <= '0;
      low_count_q     <= '0;
      confirm_count_q <= '0;
      error_flag_q    <= 1'b0;
      reset_flag_q    <= 1'b0;
    end else if (step_i) begin
      fault_age_q     <= fault_age_d;
      low_count_q     <= low_count_d;
      confirm_count_q <= confirm_count_d;
      error_flag_q    <= error_flag_d;
      reset_flag_q    <= reset_flag_d;
    end
  end

endmodule
`default_nettype wire

// File: sv/battery_voltage_window_monitor_unit.sv
// Battery voltage window monitor: top level with config, input and result registers.
// An accepted input is held in the input register, and its result then in the result register.
// Throughput: one sample per cycle while the output is not stalled, set by the band and counter
// update between the input register and the result register.
// Input is still accepted while a result waits on a stalled output, if the input register is empty.
// Reset: state, flags and pipeline valid bits clear; config registers return to defaults.
`timescale 1ns / 1ps
`default_nettype none
module battery_voltage_window_monitor_unit (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // Config write port
  input  wire logic                               cfg_we_i,
  input  wire logic [bvwm_pkg::CFG_IDX_W-1:0]     cfg_addr_i,
  input  wire logic [bvwm_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  // Sample stream
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  // [7:0] sample, [8] normal_run, [9] clear_need_reset, [15:10] zero
  input  wire logic [bvwm_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  // Result stream
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  // [0] power_error, [1] need_reset, [3:2] mute_action, [4] amp_power_cut,
  // [5] backlight_off, [6] emergency_off, [7] power_off_request
  output logic [bvwm_pkg::OUT_TDATA_W-1:0]        m_axis_tdata
);

  bvwm_pkg::cfg_t       cfg_q;
  bvwm_pkg::item_t      s1_item_q;
  logic                 s1_valid_q;
  bvwm_pkg::band_info_t band_info;
  bvwm_pkg::result_t    result;
  bvwm_pkg::result_t    out_data_q;
  logic                 out_valid_q;
  logic                 advance;
  logic                 in_fire;

  // Handshake: stage 1 moves on when the result register is free or draining
  assign advance       = s1_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !s1_valid_q || advance;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  // Config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cutoff_low     <= 8'd60;
      cfg_q.amp_cut_low    <= 8'd72;
      cfg_q.fault_low      <= 8'd108;
      cfg_q.recover_low    <= 8'd120;
      cfg_q.recover_high   <= 8'd200;
      cfg_q.fault_high     <= 8'd215;
      cfg_q.mute_delay     <= 8'd41;
      cfg_q.shutdown_delay <= 16'd500;
    end else if (cfg_we_i) begin
      unique case (bvwm_pkg::reg_idx_e'(cfg_addr_i))
        bvwm_pkg::REG_CUTOFF_LOW:     cfg_q.cutoff_low     <= cfg_wdata_i[7:0];
        bvwm_pkg::REG_AMP_CUT_LOW:    cfg_q.amp_cut_low    <= cfg_wdata_i[7:0];
        bvwm_pkg::REG_FAULT_LOW:      cfg_q.fault_low      <= cfg_wdata_i[7:0];
        bvwm_pkg::REG_RECOVER_LOW:    cfg_q.recover_low    <= cfg_wdata_i[7:0];
        bvwm_pkg::REG_RECOVER_HIGH:   cfg_q.recover_high   <= cfg_wdata_i[7:0];
        bvwm_pkg::REG_FAULT_HIGH:     cfg_q.fault_high     <= cfg_wdata_i[7:0];
        bvwm_pkg::REG_MUTE_DELAY:     cfg_q.mute_delay     <= cfg_wdata_i[7:0];
        bvwm_pkg::REG_SHUTDOWN_DELAY: cfg_q.shutdown_delay <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_item_q <= bvwm_pkg::item_t'(s_axis_tdata[$bits(bvwm_pkg::item_t)-1:0]);
    end
  end

  // Classify and update
  bvwm_band u_band (
    .sample_i (s1_item_q.sample),
    .cfg_i    (cfg_q),
    .info_o   (band_info)
  );

  bvwm_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .item_i   (s1_item_q),
    .cfg_i    (cfg_q),
    .info_i   (band_info),
    .result_o (result)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q <= result;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // Checks
  a_emerg_posts_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_data_q.emergency_off) |->
      (out_data_q.power_off_request && out_data_q.need_reset && out_data_q.power_error))
    else $error("emergency_off without power-off request and latched flags");

  a_mute_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_data_q.mute_action == bvwm_pkg::MUTE_NONE ||
                     out_data_q.mute_action == bvwm_pkg::MUTE_REQUEST ||
                     out_data_q.mute_action == bvwm_pkg::MUTE_RELEASE))
    else $error("mute_action holds an unused code");

  a_backlight_emerg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_data_q.backlight_off) |->
      (out_data_q.emergency_off && out_data_q.mute_action == bvwm_pkg::MUTE_REQUEST))
    else $error("backlight_off without emergency shutdown and mute");

  a_stall_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (s1_valid_q && out_valid_q && !m_axis_tready))
    else $error("input stalled while pipeline has room");

endmodule
`default_nettype wire

// File: dv/tb_battery_voltage_window_monitor_unit.sv
// Self-checking stream testbench for the battery voltage window monitor.
`timescale 1ns / 1ps
module tb_battery_voltage_window_monitor_unit;

  // Register values after reset
  localparam bvwm_pkg::cfg_t DEFAULT_SETTINGS = '{
    cutoff_low: 8'd60, amp_cut_low: 8'd72, fault_low: 8'd108, recover_low: 8'd120,
    recover_high: 8'd200, fault_high: 8'd215, mute_delay: 8'd41,
    shutdown_delay: 16'd500
  };

  // Tracks the monitor state and holds the reports it should produce
  class voltage_window_tracker;
    bvwm_pkg::cfg_t    settings;
    logic [15:0]       fault_age;
    logic [7:0]        low_count;
    logic [4:0]        confirm_count;
    logic              error_flag;
    logic              reset_flag;
    bvwm_pkg::result_t expected_reports[$];
    int                mismatches;

    function new();
      settings      = DEFAULT_SETTINGS;
      fault_age     = '0;
      low_count     = '0;
      confirm_count = '0;
      error_flag    = 1'b0;
      reset_flag    = 1'b0;
      mismatches    = 0;
    endfunction

    // Steps the state for one accepted sample and queues its report
    function void note_sample(bvwm_pkg::item_t it);
      bvwm_pkg::result_t r;
      logic              emerg;
      r             = '0;
      r.mute_action = bvwm_pkg::MUTE_NONE;
      emerg         = 1'b0;
      if (it.clear_need_reset) reset_flag = 1'b0;
      if (fault_age < bvwm_pkg::AGE_MAX) fault_age = fault_age + 16'd1;
      if (low_count < bvwm_pkg::LOW_MAX) low_count = low_count + 8'd1;
      if (confirm_count != '0) confirm_count = confirm_count - 5'd1;

      if (it.sample < settings.fault_low) begin
        // too low
        error_flag = 1'b1;
        if (low_count > settings.mute_delay) r.mute_action = bvwm_pkg::MUTE_REQUEST;
        if (it.sample < settings.amp_cut_low && !reset_flag) begin
          r.amp_power_cut = 1'b1;
          if (it.sample < settings.cutoff_low) begin
            reset_flag = 1'b1;
            emerg      = 1'b1;
          end
        end
        if (it.normal_run && fault_age >= settings.shutdown_delay) r.power_off_request = 1'b1;
        confirm_count = bvwm_pkg::CONFIRM_TICKS;
      end else if (it.sample < settings.recover_low) begin
        // low hysteresis
        confirm_count = bvwm_pkg::CONFIRM_TICKS;
        fault_age     = '0;
        low_count     = '0;
      end else if (it.sample < settings.recover_high) begin
        // good: recover once the confirm countdown has run out
        if (confirm_count == '0) begin
          error_flag    = 1'b0;
          r.mute_action = bvwm_pkg::MUTE_RELEASE;
        end
        fault_age = '0;
        low_count = '0;
      end else if (it.sample < settings.fault_high) begin
        // high hysteresis
        confirm_count = bvwm_pkg::CONFIRM_TICKS;
        fault_age     = '0;
        low_count     = '0;
      end else begin
        // too high; fault age keeps running
        error_flag      = 1'b1;
        reset_flag      = 1'b1;
        r.mute_action   = bvwm_pkg::MUTE_REQUEST;
        r.backlight_off = 1'b1;
        emerg           = 1'b1;
        confirm_count   = bvwm_pkg::CONFIRM_TICKS;
        low_count       = '0;
      end

      // emergency shutdown always posts a voltage power-off
      if (emerg) begin
        error_flag          = 1'b1;
        reset_flag          = 1'b1;
        r.power_off_request = 1'b1;
      end
      r.emergency_off = emerg;
      r.power_error   = error_flag;
      r.need_reset    = reset_flag;
      expected_reports.push_back(r);
    endfunction

    function void compare_field(string name, logic [1:0] want, logic [1:0] got);
      if (want !== got) begin
        mismatches++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
    endfunction

    // Compares one accepted report against the oldest expectation
    function void check_report(bvwm_pkg::result_t got);
      bvwm_pkg::result_t want;
      if (expected_reports.size() == 0) begin
        mismatches++;
        $display("%0t: report with nothing expected, expected none, actual %h", $time, got);
        return;
      end
      want = expected_reports.pop_front();
      compare_field("power_error", want.power_error, got.power_error);
      compare_field("need_reset", want.need_reset, got.need_reset);
      compare_field("mute_action", want.mute_action, got.mute_action);
      compare_field("amp_power_cut", want.amp_power_cut, got.amp_power_cut);
      compare_field("backlight_off", want.backlight_off, got.backlight_off);
      compare_field("emergency_off", want.emergency_off, got.emergency_off);
      compare_field("power_off_request", want.power_off_request, got.power_off_request);
    endfunction
  endclass

  logic                             clk_i = 1'b0;
  logic                             rst_ni;
  logic                             cfg_we_i;
  bvwm_pkg::reg_idx_e               cfg_addr_i;
  logic [bvwm_pkg::CFG_DATA_W-1:0]  cfg_wdata_i;
  logic                             s_axis_tvalid;
  logic                             s_axis_tready;
  logic [bvwm_pkg::IN_TDATA_W-1:0]  s_axis_tdata;
  logic                             m_axis_tvalid;
  logic                             m_axis_tready;
  logic [bvwm_pkg::OUT_TDATA_W-1:0] m_axis_tdata;

  voltage_window_tracker tracker;
  int   items_sent = 0;
  logic tx_quiet   = 1'b0;
  logic rx_quiet   = 1'b0;
  logic all_quiet  = 1'b0;

  battery_voltage_window_monitor_unit uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #1 clk_i = ~clk_i;

  // Sends one sample transaction after a random gap
  task automatic send_sample(logic [7:0] s, logic run, logic clr);
    bvwm_pkg::item_t it;
    int              gap;
    it.sample           = s;
    it.normal_run       = run;
    it.clear_need_reset = clr;
    gap = (all_quiet || tx_quiet) ? 0 : $urandom_range(0, 12);
    repeat (gap) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(bvwm_pkg::IN_TDATA_W - $bits(bvwm_pkg::item_t)){1'b0}}, it};
    do @(posedge clk_i); while (!s_axis_tready);
    tracker.note_sample(it);
    items_sent++;
  endtask

  // Stops sending and waits for every outstanding report
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (tracker.expected_reports.size() != 0) @(posedge clk_i);
  endtask

  task automatic settle_idle();
    wait_drained();
    repeat (4) @(posedge clk_i);
  endtask

  // Writes all eight registers while the block is idle
  task automatic load_settings(bvwm_pkg::cfg_t c);
    bvwm_pkg::reg_idx_e idx;
    logic [15:0]        value;
    settle_idle();
    for (int i = 0; i < 8; i++) begin
      idx = bvwm_pkg::reg_idx_e'(i);
      // upper byte of 8-bit registers is don't-care, so drive junk there
      value[15:8] = 8'($urandom_range(0, 255));
      case (idx)
        bvwm_pkg::REG_CUTOFF_LOW:     value[7:0] = c.cutoff_low;
        bvwm_pkg::REG_AMP_CUT_LOW:    value[7:0] = c.amp_cut_low;
        bvwm_pkg::REG_FAULT_LOW:      value[7:0] = c.fault_low;
        bvwm_pkg::REG_RECOVER_LOW:    value[7:0] = c.recover_low;
        bvwm_pkg::REG_RECOVER_HIGH:   value[7:0] = c.recover_high;
        bvwm_pkg::REG_FAULT_HIGH:     value[7:0] = c.fault_high;
        bvwm_pkg::REG_MUTE_DELAY:     value[7:0] = c.mute_delay;
        bvwm_pkg::REG_SHUTDOWN_DELAY: value = c.shutdown_delay;
        default:                      value = '0;
      endcase
      cfg_we_i    <= 1'b1;
      cfg_addr_i  <= idx;
      cfg_wdata_i <= value;
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    tracker.settings = c;
  endtask

  // Random value in [lo, hi], or anywhere when that window is empty
  function automatic logic [7:0] draw_between(int lo, int hi);
    if (lo > hi) return 8'($urandom_range(0, 255));
    return 8'($urandom_range(hi, lo));
  endfunction

  function automatic logic [7:0] draw_in_band(bvwm_pkg::band_e b);
    bvwm_pkg::cfg_t c;
    c = tracker.settings;
    case (b)
      bvwm_pkg::BAND_TOO_LOW: begin
        case ($urandom_range(0, 2))
          0:       return draw_between(0, int'(c.cutoff_low) - 1);
          1:       return draw_between(int'(c.cutoff_low), int'(c.amp_cut_low) - 1);
          default: return draw_between(int'(c.amp_cut_low), int'(c.fault_low) - 1);
        endcase
      end
      bvwm_pkg::BAND_LOW_HYST:
        return draw_between(int'(c.fault_low), int'(c.recover_low) - 1);
      bvwm_pkg::BAND_GOOD:
        return draw_between(int'(c.recover_low), int'(c.recover_high) - 1);
      bvwm_pkg::BAND_HIGH_HYST:
        return draw_between(int'(c.recover_high), int'(c.fault_high) - 1);
      default:
        return draw_between(int'(c.fault_high), 255);
    endcase
  endfunction

  // Runs of samples held in one band, with some pure noise runs mixed in
  task automatic run_random(int budget);
    int              start;
    int              len;
    int              pick;
    bvwm_pkg::band_e b;
    logic            noise;
    start = items_sent;
    while (items_sent - start < budget) begin
      b     = bvwm_pkg::band_e'($urandom_range(0, 4));
      noise = ($urandom_range(0, 9) == 0);
      pick  = $urandom_range(0, 99);
      if (pick < 60) len = $urandom_range(1, 12);
      else if (pick < 98 || tracker.settings.shutdown_delay > 600) len = $urandom_range(13, 70);
      else len = int'(tracker.settings.shutdown_delay) + $urandom_range(1, 30);
      tx_quiet = ($urandom_range(0, 4) == 0);
      repeat (len)
        send_sample(noise ? 8'($urandom_range(0, 255)) : draw_in_band(b),
                    $urandom_range(0, 3) != 0, $urandom_range(0, 7) == 0);
    end
    tx_quiet = 1'b0;
  endtask

  function automatic bvwm_pkg::cfg_t ordered_settings();
    bvwm_pkg::cfg_t c;
    int             lvl;
    lvl = $urandom_range(0, 40);           c.cutoff_low   = 8'(lvl);
    lvl = lvl + $urandom_range(1, 40);     c.amp_cut_low  = 8'(lvl);
    lvl = lvl + $urandom_range(1, 40);     c.fault_low    = 8'(lvl);
    lvl = lvl + $urandom_range(1, 40);     c.recover_low  = 8'(lvl);
    lvl = lvl + $urandom_range(1, 40);     c.recover_high = 8'(lvl);
    lvl = lvl + $urandom_range(1, 40);     c.fault_high   = 8'(lvl);
    c.mute_delay     = 8'($urandom_range(0, 60));
    c.shutdown_delay = 16'($urandom_range(0, 100));
    return c;
  endfunction

  function automatic bvwm_pkg::cfg_t unordered_settings();
    bvwm_pkg::cfg_t c;
    c.cutoff_low     = 8'($urandom_range(0, 255));
    c.amp_cut_low    = 8'($urandom_range(0, 255));
    c.fault_low      = 8'($urandom_range(0, 255));
    c.recover_low    = 8'($urandom_range(0, 255));
    c.recover_high   = 8'($urandom_range(0, 255));
    c.fault_high     = 8'($urandom_range(0, 255));
    c.mute_delay     = 8'($urandom_range(0, 255));
    c.shutdown_delay = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 200))
                                                    : 16'($urandom_range(0, 65535));
    return c;
  endfunction

  // Report sink with random back-pressure
  initial begin
    int stall;
    m_axis_tready <= 1'b0;
    do @(posedge clk_i); while (!rst_ni);
    forever begin
      if ($urandom_range(0, 39) == 0) rx_quiet = ~rx_quiet;
      stall = (all_quiet || rx_quiet) ? 0 : $urandom_range(0, 12);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      tracker.check_report(bvwm_pkg::result_t'(m_axis_tdata));
    end
  end

  // Main sequence
  initial begin
    bvwm_pkg::cfg_t c;
    tracker        = new();
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_addr_i    <= bvwm_pkg::REG_CUTOFF_LOW;
    cfg_wdata_i   <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: band edges at reset thresholds, extremes, reset-pending cases
    send_sample(8'd120, 1'b1, 1'b0);
    send_sample(8'd0,   1'b1, 1'b0);
    send_sample(8'd65,  1'b1, 1'b0);  // amp cut held off while reset pending
    send_sample(8'd65,  1'b1, 1'b1);  // cleared: amp cut again
    send_sample(8'd59,  1'b0, 1'b1);
    send_sample(8'd60,  1'b1, 1'b0);
    send_sample(8'd71,  1'b0, 1'b1);
    send_sample(8'd72,  1'b1, 1'b1);
    send_sample(8'd107, 1'b1, 1'b0);
    send_sample(8'd108, 1'b1, 1'b0);
    send_sample(8'd119, 1'b0, 1'b0);
    send_sample(8'd200, 1'b1, 1'b0);
    send_sample(8'd214, 1'b1, 1'b0);
    send_sample(8'd215, 1'b1, 1'b0);
    send_sample(8'd255, 1'b0, 1'b0);
    send_sample(8'd199, 1'b1, 1'b1);  // good band but confirm still running
    send_sample(8'd150, 1'b1, 1'b0);
    send_sample(8'd130, 1'b0, 1'b1);
    run_random(250);

    // all thresholds at zero: everything lands in the too-high band
    c = '0;
    load_settings(c);
    run_random(60);

    // all registers at maximum, mute delay past the low counter ceiling
    c = '{cutoff_low: 8'hff, amp_cut_low: 8'hff, fault_low: 8'hff, recover_low: 8'hff,
          recover_high: 8'hff, fault_high: 8'hff, mute_delay: 8'hff,
          shutdown_delay: 16'hffff};
    load_settings(c);
    run_random(150);

    load_settings(ordered_settings());
    run_random(200);

    // thresholds in no particular order
    repeat (2) begin
      load_settings(unordered_settings());
      run_random(120);
    end

    // mute delay equal to the low counter ceiling: low-band mute never fires
    c = DEFAULT_SETTINGS;
    c.mute_delay = 8'd250;
    load_settings(c);
    run_random(120);

    // long low soak without gaps: low counter saturates, shutdown fires at the delay
    c = '{cutoff_low: 8'd0, amp_cut_low: 8'd0, fault_low: 8'hff, recover_low: 8'hff,
          recover_high: 8'hff, fault_high: 8'hff, mute_delay: 8'd249,
          shutdown_delay: 16'd260};
    load_settings(c);
    all_quiet = 1'b1;
    repeat (280)
      send_sample(8'($urandom_range(0, 254)), $urandom_range(0, 7) != 0,
                  $urandom_range(0, 7) == 0);
    all_quiet = 1'b0;

    // back to reset values, with a full drain in the middle
    load_settings(DEFAULT_SETTINGS);
    run_random(120);
    wait_drained();
    run_random(120);

    settle_idle();
    if (tracker.mismatches == 0 && tracker.expected_reports.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
